// ----- rtl/cobs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_pkg
// Types and result codes shared by the stuffed-byte stream decoder.
// ----------------------------------------------------------------------------
package cobs_pkg;

  // One byte on either side of the decoder
  typedef logic [7:0] byte_t;

  // Kind of a result item
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

endpackage
`default_nettype wire

// ----- rtl/cobs_stream_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_stream_decoder
// Streaming decoder for stuffed byte frames with a programmable delimiter.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o    | in_byte_i
//  out     | output    | out_valid_o / out_ready_i  | out_byte_o, result_kind_o
//  cfg     | input     | cfg_we_i (no wait)         | cfg_wdata_i (delimiter)
//
//  One item per cycle: each accepted byte is decoded in the cycle it is taken
//  and its result, if any, lands in the output register on the same edge.
//  The result is valid in the cycle after the byte is accepted.
//  in_ready_o is high while the output register is empty or is being drained,
//  so a stall on out_ready_i holds off the input after one waiting result.
//  Reset clears the frame state, the delimiter (to zero) and the output valid.
//
module cobs_stream_decoder (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire cobs_pkg::byte_t cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire cobs_pkg::byte_t in_byte_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output cobs_pkg::byte_t      out_byte_o,
  output logic [1:0]           result_kind_o
);

  cobs_pkg::byte_t delim_q;
  logic            in_frame_q, in_frame_d;
  cobs_pkg::byte_t btc_q, btc_d;
  logic            frame_bad_q, frame_bad_d;
  logic            has_data_q, has_data_d;
  logic            out_valid_q, out_valid_d;
  cobs_pkg::byte_t out_byte_q, out_byte_d;
  cobs_pkg::kind_e out_kind_q, out_kind_d;
  logic            res_valid;

  logic in_fire;
  logic is_delim;
  logic at_code;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_delim   = (in_byte_i == delim_q);
  assign at_code    = !frame_bad_q && (btc_q == 8'd1);

  // Decode one item against the frame state
  always_comb begin
    in_frame_d  = in_frame_q;
    btc_d       = btc_q;
    frame_bad_d = frame_bad_q;
    has_data_d  = has_data_q;
    res_valid   = 1'b0;
    out_byte_d  = in_byte_i;
    out_kind_d  = cobs_pkg::KIND_DATA;
    if (!in_frame_q) begin
      // Open a frame on the code byte, drop lone delimiters
      if (!is_delim) begin
        in_frame_d  = 1'b1;
        btc_d       = in_byte_i;
        frame_bad_d = (in_byte_i == 8'd0);
        has_data_d  = 1'b0;
      end
    end else if (is_delim) begin
      // Close the frame with its end item
      in_frame_d  = 1'b0;
      btc_d       = 8'd0;
      frame_bad_d = 1'b0;
      has_data_d  = 1'b0;
      res_valid   = 1'b1;
      out_byte_d  = 8'd0;
      priority if (!at_code) begin
        out_kind_d = cobs_pkg::KIND_BAD;
      end else if (!has_data_q) begin
        out_kind_d = cobs_pkg::KIND_EMPTY;
      end else begin
        out_kind_d = cobs_pkg::KIND_GOOD;
      end
    end else begin
      // Pass data through; a code position becomes the delimiter
      has_data_d = 1'b1;
      res_valid  = 1'b1;
      if (at_code) begin
        btc_d      = in_byte_i;
        out_byte_d = delim_q;
        if (in_byte_i == 8'd0) begin
          frame_bad_d = 1'b1;
        end
      end else begin
        btc_d = btc_q - 8'd1;
      end
    end
  end

  // Advance the output valid: load on a result, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q     <= 8'd0;
      in_frame_q  <= 1'b0;
      btc_q       <= 8'd0;
      frame_bad_q <= 1'b0;
      has_data_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        in_frame_q  <= in_frame_d;
        btc_q       <= btc_d;
        frame_bad_q <= frame_bad_d;
        has_data_q  <= has_data_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_byte_q <= out_byte_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign result_kind_o = out_kind_q;

  // Idle frame state is fully cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (btc_q == 8'd0) && !frame_bad_q && !has_data_q)
    else $error("frame state not cleared outside a frame");

  // End items carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_q != cobs_pkg::KIND_DATA) |-> out_byte_o == 8'd0)
    else $error("end item with nonzero byte");

  // A delimiter inside a frame closes it with an end item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_frame_q && is_delim |=>
      !in_frame_q && out_valid_o && (out_kind_q != cobs_pkg::KIND_DATA))
    else $error("delimiter did not close the frame");

  // Bytes taken outside a frame produce no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_frame_q |=> !out_valid_o)
    else $error("result produced outside a frame");

endmodule
`default_nettype wire
